// ===== rtl/smf_pkg.sv =====
package smf_pkg;

  typedef enum logic [3:0] {
    KIND_OFF      = 4'd0,
    KIND_ON       = 4'd1,
    KIND_KEYPRESS = 4'd2,
    KIND_CONTROL  = 4'd3,
    KIND_PROGRAM  = 4'd4,
    KIND_CHANPRES = 4'd5,
    KIND_BEND     = 4'd6,
    KIND_TEMPO    = 4'd7,
    KIND_END      = 4'd8,
    KIND_DONE     = 4'd9,
    KIND_ERROR    = 4'd10
  } kind_e;

  typedef enum logic [17:0] {
    PH_MTHD      = 18'h00001,
    PH_HLEN      = 18'h00002,
    PH_FMT       = 18'h00004,
    PH_TRK       = 18'h00008,
    PH_DIV       = 18'h00010,
    PH_MTRK      = 18'h00020,
    PH_TLEN      = 18'h00040,
    PH_DELTA     = 18'h00080,
    PH_STATUS    = 18'h00100,
    PH_DATA1     = 18'h00200,
    PH_DATA2     = 18'h00400,
    PH_DATA_ONE  = 18'h00800,
    PH_META_TYPE = 18'h01000,
    PH_META_FIX  = 18'h02000,
    PH_META_VLEN = 18'h04000,
    PH_SKIP      = 18'h08000,
    PH_TEMPO     = 18'h10000,
    PH_SYSEX     = 18'h20000
  } phase_e;

  localparam logic [25:0] UsPerMinute = 26'd60000000;

  // one classified result going from front to back
  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] etime;
    logic [3:0]  chan;
    logic [7:0]  d1;
    logic [7:0]  d2;
    logic [23:0] tempo;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  event_kind;
    logic [31:0] event_time;
    logic [3:0]  channel;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [25:0] tempo_bpm;
    logic        run_last;
  } result_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       final_byte;
  } item_t;

endpackage

// ===== rtl/smf_stream_if.sv =====
interface smf_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/smf_front.sv =====
module smf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  smf_pkg::item_t      in_item_i,
  output logic                cmd_valid_o,
  output smf_pkg::cmd_t [1:0] cmd_o,
  output logic                cmd_two_o,
  input  logic                cmd_space_i
);

  smf_pkg::phase_e phase_q, phase_d;
  logic [31:0] cnt_q, cnt_d, acc_q, acc_d, rtime_q, rtime_d;
  logic [7:0]  status_q, status_d, dhold_q, dhold_d;
  logic [23:0] tempo_q, tempo_d;
  logic [15:0] fmt_q, fmt_d, trk_q, trk_d;
  logic        halt_q, halt_d;
  logic [7:0]  b;
  logic        fin, fire;
  logic [1:0]  n;
  smf_pkg::cmd_t [1:0] c;

  assign in_ready_o = cmd_space_i;
  assign fire = in_valid_i && cmd_space_i;
  assign b = in_item_i.byte_in;
  assign fin = in_item_i.final_byte;

  // parse one byte
  always_comb begin
    logic [7:0] m;
    logic [7:0] flen;
    logic [31:0] nt;
    smf_pkg::cmd_t base;
    phase_d = phase_q; cnt_d = cnt_q; acc_d = acc_q; rtime_d = rtime_q;
    status_d = status_q; dhold_d = dhold_q; tempo_d = tempo_q;
    fmt_d = fmt_q; trk_d = trk_q; halt_d = halt_q;
    n = 2'd0;
    m = 8'h00; flen = 8'd1; nt = 32'd0;
    base = '0;
    c = '0;
    if (!halt_q) begin
      unique case (phase_q)
        smf_pkg::PH_MTHD, smf_pkg::PH_MTRK: begin
          case (cnt_q[1:0])
            2'd0: m = 8'h4d;
            2'd1: m = 8'h54;
            2'd2: m = (phase_q == smf_pkg::PH_MTHD) ? 8'h68 : 8'h72;
            default: m = (phase_q == smf_pkg::PH_MTHD) ? 8'h64 : 8'h6b;
          endcase
          if (b != m) begin
            halt_d = 1'b1; c[0].kind = smf_pkg::KIND_ERROR; n = 2'd1;
          end else if (cnt_q + 32'd1 >= 32'd4) begin
            phase_d = (phase_q == smf_pkg::PH_MTHD) ? smf_pkg::PH_HLEN : smf_pkg::PH_TLEN;
            cnt_d = '0; acc_d = '0;
          end else begin
            cnt_d = cnt_q + 32'd1;
          end
        end
        smf_pkg::PH_HLEN: begin
          acc_d = {acc_q[23:0], b};
          cnt_d = cnt_q + 32'd1;
          if (cnt_d >= 32'd4) begin
            if (acc_d != 32'd6) begin
              halt_d = 1'b1; c[0].kind = smf_pkg::KIND_ERROR; n = 2'd1;
            end else begin
              phase_d = smf_pkg::PH_FMT; cnt_d = '0; acc_d = '0;
            end
          end
        end
        smf_pkg::PH_FMT: begin
          fmt_d = {fmt_q[7:0], b};
          cnt_d = cnt_q + 32'd1;
          if (cnt_d >= 32'd2) begin
            phase_d = smf_pkg::PH_TRK; cnt_d = '0; acc_d = '0;
          end
        end
        smf_pkg::PH_TRK: begin
          trk_d = {trk_q[7:0], b};
          cnt_d = cnt_q + 32'd1;
          if (cnt_d >= 32'd2) begin
            phase_d = smf_pkg::PH_DIV; cnt_d = '0; acc_d = '0;
          end
        end
        smf_pkg::PH_DIV: begin
          cnt_d = cnt_q + 32'd1;
          if (cnt_d >= 32'd2) begin
            if (fmt_q == 16'd1 || fmt_q == 16'd2) begin
              halt_d = 1'b1; c[0].kind = smf_pkg::KIND_DONE; n = 2'd1;
            end else if (fmt_q != 16'd0 || trk_q != 16'd1) begin
              halt_d = 1'b1; c[0].kind = smf_pkg::KIND_ERROR; n = 2'd1;
            end else begin
              phase_d = smf_pkg::PH_MTRK; cnt_d = '0; acc_d = '0;
            end
          end
        end
        smf_pkg::PH_TLEN: begin
          cnt_d = cnt_q + 32'd1;
          if (cnt_d >= 32'd4) begin
            phase_d = smf_pkg::PH_DELTA; cnt_d = '0; acc_d = '0;
          end
        end
        smf_pkg::PH_DELTA: begin
          acc_d = {acc_q[24:0], 7'd0} + {25'd0, b[6:0]};
          cnt_d = 32'd1;
          if (!b[7]) begin
            rtime_d = rtime_q + acc_d;
            phase_d = smf_pkg::PH_STATUS; cnt_d = '0; acc_d = '0;
          end
        end
        smf_pkg::PH_STATUS: begin
          cnt_d = '0; acc_d = '0;
          if (b == 8'hff) phase_d = smf_pkg::PH_META_TYPE;
          else if (b == 8'hf0) phase_d = smf_pkg::PH_SYSEX;
          else if (b >= 8'h80 && b <= 8'hef) begin
            status_d = b;
            phase_d = (b >= 8'hc0 && b <= 8'hdf) ? smf_pkg::PH_DATA_ONE : smf_pkg::PH_DATA1;
          end else phase_d = smf_pkg::PH_DELTA;
        end
        smf_pkg::PH_DATA1: begin
          dhold_d = b; phase_d = smf_pkg::PH_DATA2;
        end
        smf_pkg::PH_DATA2, smf_pkg::PH_DATA_ONE: begin
          c[0].kind = {1'b0, status_q[6:4]};
          c[0].chan = status_q[3:0];
          c[0].d1 = (phase_q == smf_pkg::PH_DATA2) ? dhold_q : b;
          c[0].d2 = (phase_q == smf_pkg::PH_DATA2) ? b : 8'd0;
          n = 2'd1;
          phase_d = smf_pkg::PH_DELTA; cnt_d = '0; acc_d = '0;
        end
        smf_pkg::PH_META_TYPE: begin
          dhold_d = b;
          cnt_d = '0; acc_d = '0;
          if ((b >= 8'h01 && b <= 8'h09) || b == 8'h7f) phase_d = smf_pkg::PH_META_VLEN;
          else if (b == 8'h00 || b == 8'h2f || b == 8'h51 || b == 8'h54 ||
                   b == 8'h58 || b == 8'h59 || b == 8'h20 || b == 8'h21)
            phase_d = smf_pkg::PH_META_FIX;
          else begin
            halt_d = 1'b1; c[0].kind = smf_pkg::KIND_ERROR; n = 2'd1;
            cnt_d = cnt_q; acc_d = acc_q;
          end
        end
        smf_pkg::PH_META_FIX: begin
          case (dhold_q)
            8'h54: flen = 8'd5;
            8'h58: flen = 8'd4;
            8'h59: flen = 8'd2;
            default: flen = 8'd1;
          endcase
          if (dhold_q == 8'h2f) begin
            if (b == 8'h00) begin
              c[0].kind = smf_pkg::KIND_END; c[1].kind = smf_pkg::KIND_DONE;
              n = 2'd2; halt_d = 1'b1;
            end else begin
              halt_d = 1'b1; c[0].kind = smf_pkg::KIND_ERROR; n = 2'd1;
            end
          end else if (dhold_q == 8'h51) begin
            if (b == 8'h03) begin
              phase_d = smf_pkg::PH_TEMPO; cnt_d = '0; acc_d = '0; tempo_d = '0;
            end else begin
              halt_d = 1'b1; c[0].kind = smf_pkg::KIND_ERROR; n = 2'd1;
            end
          end else if ((dhold_q == 8'h00 && (b == 8'h00 || b == 8'h02)) ||
                       (dhold_q != 8'h00 && b == flen)) begin
            if (b == 8'h00) begin
              phase_d = smf_pkg::PH_DELTA; cnt_d = '0; acc_d = '0;
            end else begin
              phase_d = smf_pkg::PH_SKIP; cnt_d = {24'd0, b};
            end
          end else begin
            halt_d = 1'b1; c[0].kind = smf_pkg::KIND_ERROR; n = 2'd1;
          end
        end
        smf_pkg::PH_META_VLEN: begin
          nt = {acc_q[24:0], 7'd0} + {25'd0, b[6:0]};
          acc_d = nt;
          if (!b[7]) begin
            if (nt == 32'd0) begin
              phase_d = smf_pkg::PH_DELTA; cnt_d = '0; acc_d = '0;
            end else begin
              phase_d = smf_pkg::PH_SKIP; cnt_d = nt;
            end
          end
        end
        smf_pkg::PH_SKIP: begin
          if (cnt_q <= 32'd1) begin
            phase_d = smf_pkg::PH_DELTA; cnt_d = '0; acc_d = '0;
          end else cnt_d = cnt_q - 32'd1;
        end
        smf_pkg::PH_TEMPO: begin
          tempo_d = {tempo_q[15:0], b};
          cnt_d = cnt_q + 32'd1;
          if (cnt_d >= 32'd3) begin
            if (tempo_d == 24'd0) begin
              halt_d = 1'b1; c[0].kind = smf_pkg::KIND_ERROR; n = 2'd1;
            end else begin
              c[0].kind = smf_pkg::KIND_TEMPO; c[0].tempo = tempo_d; n = 2'd1;
              phase_d = smf_pkg::PH_DELTA; cnt_d = '0; acc_d = '0;
            end
          end
        end
        smf_pkg::PH_SYSEX: begin
          if (b == 8'hf7) begin
            phase_d = smf_pkg::PH_DELTA; cnt_d = '0; acc_d = '0;
          end
        end
        default: begin
          halt_d = 1'b1; c[0].kind = smf_pkg::KIND_ERROR; n = 2'd1;
        end
      endcase
      // end of data
      if (!halt_d && fin) begin
        base.kind = (phase_d == smf_pkg::PH_DELTA && cnt_d == 32'd0) ?
                    smf_pkg::KIND_DONE : smf_pkg::KIND_ERROR;
        if (n == 2'd0) c[0] = base;
        else c[1] = base;
        n = n + 2'd1;
        halt_d = 1'b1;
      end
      c[0].etime = rtime_d;
      c[1].etime = rtime_d;
      c[0].last = (n == 2'd1);
      c[1].last = 1'b1;
    end
  end

  assign cmd_valid_o = fire && (n != 2'd0);
  assign cmd_two_o = (n == 2'd2);
  assign cmd_o = c;

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= smf_pkg::PH_MTHD;
      cnt_q <= '0; acc_q <= '0; rtime_q <= '0; status_q <= '0; dhold_q <= '0;
      tempo_q <= '0; fmt_q <= '0; trk_q <= '0; halt_q <= 1'b0;
    end else if (fire) begin
      phase_q <= phase_d;
      cnt_q <= cnt_d; acc_q <= acc_d; rtime_q <= rtime_d; status_q <= status_d;
      dhold_q <= dhold_d; tempo_q <= tempo_d; fmt_q <= fmt_d; trk_q <= trk_d;
      halt_q <= halt_d;
    end
  end

endmodule

// ===== rtl/smf_queue.sv =====
module smf_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic                two_i,
  input  smf_pkg::cmd_t [1:0] data_i,
  output logic                space_o,
  output logic                valid_o,
  output smf_pkg::cmd_t       data_o,
  input  logic                pop_i
);

  smf_pkg::cmd_t mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic [2:0] add;

  assign space_o = (cnt_q <= 3'd2);
  assign valid_o = (cnt_q != 3'd0);
  assign data_o = mem_q[rp_q];
  assign add = push_i ? (two_i ? 3'd2 : 3'd1) : 3'd0;

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i[0];
      if (two_i) mem_q[wp_q + 2'd1] <= data_i[1];
    end
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q <= wp_q + add[1:0];
      if (pop_i) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + add - {2'd0, pop_i};
    end
  end

`ifndef SYNTH
  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4) else $error("queue overflow");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop of empty queue");
  a_push_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> space_o) else $error("push without space");
`endif

endmodule

// ===== rtl/smf_back.sv =====
module smf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  smf_pkg::cmd_t   cmd_i,
  output logic            cmd_pop_o,
  output logic            out_valid_o,
  output smf_pkg::result_t out_o,
  input  logic            out_ready_i
);

  // restoring divider, one quotient bit a cycle
  logic        busy_q;
  logic [4:0]  step_q;
  logic [25:0] quo_q;
  logic [24:0] rem_q;
  logic [25:0] num_q;
  logic        ovalid_q;
  smf_pkg::result_t res_q;
  logic [25:0] trial;
  logic        take, is_tempo, load;

  assign is_tempo = (cmd_i.kind == smf_pkg::KIND_TEMPO);
  assign load = cmd_valid_i && !busy_q && (!ovalid_q || out_ready_i);
  assign cmd_pop_o = load && !is_tempo ||
                     busy_q && step_q == 5'd0 && (!ovalid_q || out_ready_i);
  assign trial = {rem_q, num_q[25]} - {2'd0, cmd_i.tempo};
  assign take = !trial[25];

  always_ff @(posedge clk_i) begin
    if (busy_q && step_q != 5'd0) begin
      rem_q <= take ? trial[24:0] : {rem_q[23:0], num_q[25]};
      num_q <= {num_q[24:0], 1'b0};
      quo_q <= {quo_q[24:0], take};
    end else if (load && is_tempo) begin
      rem_q <= '0; num_q <= smf_pkg::UsPerMinute; quo_q <= '0;
    end
    if (cmd_pop_o) begin
      res_q.event_kind  <= cmd_i.kind;
      res_q.event_time  <= cmd_i.etime;
      res_q.channel     <= cmd_i.chan;
      res_q.first_data  <= cmd_i.d1;
      res_q.second_data <= cmd_i.d2;
      res_q.tempo_bpm   <= busy_q ? quo_q : 26'd0;
      res_q.run_last    <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; step_q <= '0; ovalid_q <= 1'b0;
    end else begin
      if (load && is_tempo) begin
        busy_q <= 1'b1; step_q <= 5'd26;
      end else if (busy_q && step_q != 5'd0) step_q <= step_q - 5'd1;
      else if (cmd_pop_o) busy_q <= 1'b0;
      if (cmd_pop_o) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_o = res_q;

`ifndef SYNTH
  a_busy_tempo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cmd_valid_i && is_tempo) else $error("divider lost its item");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !out_ready_i |=> ovalid_q && $stable(res_q)) else $error("result dropped");
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> step_q == 5'd0) else $error("stray divider step");
`endif

endmodule

// ===== rtl/smf_track_event_parser.sv =====
// ordinary events pass from the byte transfer through the result queue and the output register
// tempo results also wait for the 26-step serial divider
// throughput: one byte per cycle while the 4-entry result queue has room
// reset (async, active low) returns the parser to the file header magic
// and empties the queue and output register
module smf_track_event_parser (
  input logic clk_i,
  input logic rst_ni,
  smf_stream_if.sink   in_i,
  smf_stream_if.source out_o
);

  logic                cmd_valid, cmd_two, space, q_valid, pop;
  smf_pkg::cmd_t [1:0] cmd;
  smf_pkg::cmd_t       q_data;
  smf_pkg::result_t    res;

  smf_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid), .in_ready_o(in_i.ready), .in_item_i(in_i.payload),
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_two_o(cmd_two), .cmd_space_i(space)
  );

  smf_queue u_queue (
    .clk_i, .rst_ni, .push_i(cmd_valid), .two_i(cmd_two), .data_i(cmd),
    .space_o(space), .valid_o(q_valid), .data_o(q_data), .pop_i(pop)
  );

  smf_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(q_valid), .cmd_i(q_data), .cmd_pop_o(pop),
    .out_valid_o(out_o.valid), .out_o(res), .out_ready_i(out_o.ready)
  );

  assign out_o.payload = res;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import smf_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int MaxShown   = 10;

  logic clk_i;
  logic rst_ni;

  smf_stream_if #(.payload_t(item_t))   byte_if ();
  smf_stream_if #(.payload_t(result_t)) event_if ();

  smf_track_event_parser i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if.sink),
    .out_o  (event_if.source)
  );

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // parser state mirror
  phase_e      pr_phase;
  logic [31:0] pr_count;
  logic [31:0] pr_varlen;
  logic [31:0] pr_time;
  logic [7:0]  pr_status;
  logic [7:0]  pr_data;
  logic [23:0] pr_tempo;
  logic [15:0] pr_format;
  logic [15:0] pr_tracks;
  logic        pr_halted;

  result_t event_q[$];
  item_t   byte_q[$];
  int      mismatches;
  int      cycles;
  bit      quiet;

  const logic [7:0] head_magic[4]  = '{8'h4d, 8'h54, 8'h68, 8'h64};
  const logic [7:0] track_magic[4] = '{8'h4d, 8'h54, 8'h72, 8'h6b};

  function automatic result_t make_event(kind_e k, logic [3:0] ch, logic [7:0] d1,
                                         logic [7:0] d2, logic [25:0] bpm);
    result_t r;
    r.event_kind  = k;
    r.event_time  = pr_time;
    r.channel     = ch;
    r.first_data  = d1;
    r.second_data = d2;
    r.tempo_bpm   = bpm;
    r.run_last    = 1'b0;
    return r;
  endfunction

  function automatic void enter(phase_e p);
    pr_phase  = p;
    pr_count  = 0;
    pr_varlen = 0;
  endfunction

  function automatic void skip_data(logic [31:0] len);
    if (len == 0) begin
      enter(PH_DELTA);
    end else begin
      pr_phase = PH_SKIP;
      pr_count = len;
    end
  endfunction

  // advance the parser by one byte, giving the events it causes
  task automatic parse_byte(input logic [7:0] b, input logic fin,
                            output result_t ev[2], output int n);
    logic [7:0] want;
    n = 0;
    if (pr_halted) return;
    case (pr_phase)
      PH_MTHD, PH_MTRK: begin
        want = (pr_phase == PH_MTHD) ? head_magic[pr_count[1:0]]
                                     : track_magic[pr_count[1:0]];
        if (b != want) begin
          pr_halted = 1'b1;
          ev[n++] = make_event(KIND_ERROR, 0, 0, 0, 0);
        end else if (++pr_count >= 4) begin
          enter(pr_phase == PH_MTHD ? PH_HLEN : PH_TLEN);
        end
      end
      PH_HLEN: begin
        pr_varlen = (pr_varlen << 8) | b;
        if (++pr_count >= 4) begin
          if (pr_varlen != 6) begin
            pr_halted = 1'b1;
            ev[n++] = make_event(KIND_ERROR, 0, 0, 0, 0);
          end else enter(PH_FMT);
        end
      end
      PH_FMT: begin
        pr_format = {pr_format[7:0], b};
        if (++pr_count >= 2) enter(PH_TRK);
      end
      PH_TRK: begin
        pr_tracks = {pr_tracks[7:0], b};
        if (++pr_count >= 2) enter(PH_DIV);
      end
      PH_DIV: begin
        if (++pr_count >= 2) begin
          if (pr_format == 1 || pr_format == 2) begin
            pr_halted = 1'b1;
            ev[n++] = make_event(KIND_DONE, 0, 0, 0, 0);
          end else if (pr_format != 0 || pr_tracks != 1) begin
            pr_halted = 1'b1;
            ev[n++] = make_event(KIND_ERROR, 0, 0, 0, 0);
          end else enter(PH_MTRK);
        end
      end
      PH_TLEN: if (++pr_count >= 4) enter(PH_DELTA);
      PH_DELTA: begin
        pr_varlen = (pr_varlen << 7) + b[6:0];
        pr_count  = 1;
        if (!b[7]) begin
          pr_time += pr_varlen;
          enter(PH_STATUS);
        end
      end
      PH_STATUS: begin
        if (b == 8'hff) enter(PH_META_TYPE);
        else if (b == 8'hf0) enter(PH_SYSEX);
        else if (b >= 8'h80 && b <= 8'hef) begin
          pr_status = b;
          enter((b >= 8'hc0 && b <= 8'hdf) ? PH_DATA_ONE : PH_DATA1);
        end else enter(PH_DELTA);
      end
      PH_DATA1: begin
        pr_data  = b;
        pr_phase = PH_DATA2;
      end
      PH_DATA2: begin
        ev[n++] = make_event(kind_e'(pr_status[7:4] - 4'd8), pr_status[3:0], pr_data, b, 0);
        enter(PH_DELTA);
      end
      PH_DATA_ONE: begin
        ev[n++] = make_event(kind_e'(pr_status[7:4] - 4'd8), pr_status[3:0], b, 0, 0);
        enter(PH_DELTA);
      end
      PH_META_TYPE: begin
        pr_data = b;
        if ((b >= 8'h01 && b <= 8'h09) || b == 8'h7f) enter(PH_META_VLEN);
        else if (b inside {8'h00, 8'h2f, 8'h51, 8'h54, 8'h58, 8'h59, 8'h20, 8'h21})
          enter(PH_META_FIX);
        else begin
          pr_halted = 1'b1;
          ev[n++] = make_event(KIND_ERROR, 0, 0, 0, 0);
        end
      end
      PH_META_FIX: begin
        case (pr_data)
          8'h00: want = (b == 8'h02) ? 8'h02 : 8'h00;
          8'h2f: want = 8'h00;
          8'h51: want = 8'h03;
          8'h54: want = 8'h05;
          8'h58: want = 8'h04;
          8'h59: want = 8'h02;
          default: want = 8'h01;
        endcase
        if (b != want) begin
          pr_halted = 1'b1;
          ev[n++] = make_event(KIND_ERROR, 0, 0, 0, 0);
        end else if (pr_data == 8'h2f) begin
          ev[n++] = make_event(KIND_END, 0, 0, 0, 0);
          ev[n++] = make_event(KIND_DONE, 0, 0, 0, 0);
          pr_halted = 1'b1;
        end else if (pr_data == 8'h51) begin
          enter(PH_TEMPO);
          pr_tempo = 0;
        end else skip_data(b);
      end
      PH_META_VLEN: begin
        pr_varlen = (pr_varlen << 7) + b[6:0];
        if (!b[7]) skip_data(pr_varlen);
      end
      PH_SKIP: if (pr_count <= 1) enter(PH_DELTA); else pr_count--;
      PH_TEMPO: begin
        pr_tempo = {pr_tempo[15:0], b};
        if (++pr_count >= 3) begin
          if (pr_tempo == 0) begin
            pr_halted = 1'b1;
            ev[n++] = make_event(KIND_ERROR, 0, 0, 0, 0);
          end else begin
            ev[n++] = make_event(KIND_TEMPO, 0, 0, 0, 26'(32'd60000000 / pr_tempo));
            enter(PH_DELTA);
          end
        end
      end
      PH_SYSEX: if (b == 8'hf7) enter(PH_DELTA);
      default: begin
        pr_halted = 1'b1;
        ev[n++] = make_event(KIND_ERROR, 0, 0, 0, 0);
      end
    endcase
    // end of data
    if (!pr_halted && fin) begin
      if (pr_phase == PH_DELTA && pr_count == 0) ev[n++] = make_event(KIND_DONE, 0, 0, 0, 0);
      else ev[n++] = make_event(KIND_ERROR, 0, 0, 0, 0);
      pr_halted = 1'b1;
    end
    if (n > 0) ev[n-1].run_last = 1'b1;
  endtask

  // byte transfer with random gaps; the events are predicted before handing over
  task automatic send_byte(input item_t it, input int typed_n, input result_t typed);
    result_t ev[2];
    int      n;
    parse_byte(it.byte_in, it.final_byte, ev, n);
    if (typed_n < 0) begin
      for (int i = 0; i < n; i++) event_q.push_back(ev[i]);
    end else if (typed_n > 0) begin
      event_q.push_back(typed);
    end
    if (!quiet && $urandom_range(0, 7) == 0) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    byte_if.valid   <= 1'b1;
    byte_if.payload <= it;
    forever begin
      @(negedge clk_i);
      if (byte_if.ready) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
  endtask

  function automatic item_t mk_item(logic [7:0] b, logic fin);
    item_t it;
    it.byte_in    = b;
    it.final_byte = fin;
    return it;
  endfunction

  task automatic add_byte(input logic [7:0] b);
    byte_q.push_back(mk_item(b, 1'b0));
  endtask

  // variable-length number of random content, occasionally long enough to wrap
  task automatic add_varlen(input int max_bytes);
    int nb;
    nb = ($urandom_range(0, 19) == 0) ? max_bytes : $urandom_range(1, 2);
    for (int i = 0; i < nb - 1; i++) add_byte(8'h80 | 8'($urandom_range(0, 127)));
    add_byte(8'($urandom_range(0, 127)));
  endtask

  // one well-formed or noisy track event with random content
  task automatic add_track_event();
    int         pick;
    int         len;
    logic [7:0] b;
    add_varlen(6);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      add_byte(8'($urandom_range(8'h80, 8'hef)));
      add_byte(8'($urandom_range(0, 255)));
      if (byte_q[$-1].byte_in < 8'hc0 || byte_q[$-1].byte_in > 8'hdf)
        add_byte(8'($urandom_range(0, 255)));
    end else if (pick < 55) begin
      // tempo, with the extremes of the beat length now and then
      add_byte(8'hff); add_byte(8'h51); add_byte(8'h03);
      case ($urandom_range(0, 3))
        0: begin add_byte(8'h00); add_byte(8'h00); add_byte(8'h01); end
        1: begin add_byte(8'hff); add_byte(8'hff); add_byte(8'hff); end
        default: begin
          add_byte(8'($urandom_range(1, 255)));
          add_byte(8'($urandom_range(0, 255)));
          add_byte(8'($urandom_range(0, 255)));
        end
      endcase
    end else if (pick < 63) begin
      add_byte(8'hf0);
      repeat ($urandom_range(0, 5)) begin
        do b = 8'($urandom_range(0, 255)); while (b == 8'hf7);
        add_byte(b);
      end
      add_byte(8'hf7);
    end else if (pick < 72) begin
      add_byte(8'hff);
      add_byte(($urandom_range(0, 9) == 0) ? 8'h7f : 8'($urandom_range(1, 9)));
      len = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) add_byte(8'h80);
      add_byte(8'(len));
      repeat (len) add_byte(8'($urandom_range(0, 255)));
    end else if (pick < 82) begin
      add_byte(8'hff);
      case ($urandom_range(0, 5))
        0: begin add_byte(8'h54); len = 5; end
        1: begin add_byte(8'h58); len = 4; end
        2: begin add_byte(8'h59); len = 2; end
        3: begin add_byte(8'h20); len = 1; end
        4: begin add_byte(8'h21); len = 1; end
        default: begin add_byte(8'h00); len = $urandom_range(0, 1) * 2; end
      endcase
      add_byte(8'(len));
      repeat (len) add_byte(8'($urandom_range(0, 255)));
    end else begin
      // stray status or data byte, skipped on its own
      do b = 8'($urandom_range(0, 255));
      while (b == 8'hf0 || b == 8'hff || (b >= 8'h80 && b <= 8'hef));
      add_byte(b);
    end
  endtask

  // result side: random stalls, check at the falling edge before the transfer
  initial begin
    int stall;
    stall = 0;
    event_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall > 0) stall--;
      else if (!quiet && $urandom_range(0, 9) == 0) stall = $urandom_range(1, 11);
      event_if.ready <= (stall == 0);
    end
  end

  always @(negedge clk_i) begin
    result_t got, want;
    if (rst_ni && event_if.valid && event_if.ready) begin
      got = event_if.payload;
      if (event_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown) $display("unexpected event %p", got);
      end else begin
        want = event_q.pop_front();
        if (got.event_kind !== want.event_kind || got.event_time !== want.event_time ||
            got.channel !== want.channel || got.first_data !== want.first_data ||
            got.second_data !== want.second_data || got.tempo_bpm !== want.tempo_bpm ||
            got.run_last !== want.run_last) begin
          mismatches++;
          if (mismatches <= MaxShown) $display("event mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  typedef struct {
    logic [7:0] b;
    int         n;
    result_t    r;
  } row_t;

  function automatic row_t row(logic [7:0] b, int n, result_t r = '0);
    row_t x;
    x.b = b;
    x.n = n;
    x.r = r;
    return x;
  endfunction

  initial begin
    row_t    rows[$];
    result_t note;
    int      ending;
    int      total;
    cycles     = 0;
    mismatches = 0;
    quiet      = 1'b0;
    pr_phase   = PH_MTHD;
    pr_count   = 0;
    pr_varlen  = 0;
    pr_time    = 0;
    pr_status  = 0;
    pr_data    = 0;
    pr_tempo   = 0;
    pr_format  = 0;
    pr_tracks  = 0;
    pr_halted  = 1'b0;
    byte_if.valid   <= 1'b0;
    byte_if.payload <= '0;

    // directed: header and an extreme note on
    foreach (head_magic[i]) rows.push_back(row(head_magic[i], 0));
    rows.push_back(row(8'h00, 0)); rows.push_back(row(8'h00, 0));
    rows.push_back(row(8'h00, 0)); rows.push_back(row(8'h06, 0));
    rows.push_back(row(8'h00, 0)); rows.push_back(row(8'h00, 0));
    rows.push_back(row(8'h00, 0)); rows.push_back(row(8'h01, 0));
    rows.push_back(row(8'h00, 0)); rows.push_back(row(8'h60, 0));
    foreach (track_magic[i]) rows.push_back(row(track_magic[i], 0));
    rows.push_back(row(8'hff, 0)); rows.push_back(row(8'hff, 0));
    rows.push_back(row(8'hff, 0)); rows.push_back(row(8'hff, 0));
    rows.push_back(row(8'h81, 0)); rows.push_back(row(8'h00, 0));
    note = '{event_kind: KIND_ON, event_time: 32'd128, channel: 4'hf,
             first_data: 8'hff, second_data: 8'h80, tempo_bpm: 26'd0, run_last: 1'b1};
    rows.push_back(row(8'h9f, 0)); rows.push_back(row(8'hff, 0));
    rows.push_back(row(8'h80, 1, note));
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    foreach (rows[i]) send_byte(mk_item(rows[i].b, 1'b0), rows[i].n, rows[i].r);

    // random track events, then one way of ending the file
    while (byte_q.size() < 1080) add_track_event();
    ending = $urandom_range(0, 4);
    add_varlen(2);
    case (ending)
      0: begin add_byte(8'hff); add_byte(8'h2f); add_byte(8'h00); end
      1: begin add_byte(8'hc5); add_byte(8'h7f); byte_q[$].final_byte = 1'b1; end
      2: begin
        add_byte(8'hff); add_byte(8'h51); add_byte(8'h03);
        add_byte(8'h00); add_byte(8'h00); add_byte(8'h00);
      end
      3: begin add_byte(8'hff); add_byte(8'h7e); end
      default: begin add_byte(8'h90); add_byte(8'h3c); byte_q[$].final_byte = 1'b1; end
    endcase
    // bytes after the parser has stopped are ignored
    repeat (8) byte_q.push_back(mk_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
    total = byte_q.size();
    foreach (byte_q[i]) begin
      if (i > total * 85 / 100) quiet = 1'b1;
      send_byte(byte_q[i], -1, '0);
    end
    byte_if.valid <= 1'b0;

    while (event_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && event_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
